// ===== rtl/rdc_pkg.sv =====
package rdc_pkg;

  // Fixed field widths
  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned RADIX_BITS = 6;
  localparam int unsigned CHAR_BITS  = 7;

  // Radix limits
  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd62;
  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;

  // Alphabet bounds: 0-9, A-Z, a-z
  localparam logic [RADIX_BITS-1:0] DIG_LAST_NUM = 6'd9;
  localparam logic [RADIX_BITS-1:0] DIG_LAST_UC  = 6'd35;
  localparam logic [RADIX_BITS-1:0] DIG_LAST_LC  = 6'd61;
  localparam logic [CHAR_BITS-1:0]  OFS_NUM      = 7'd48;
  localparam logic [CHAR_BITS-1:0]  OFS_UC       = 7'd55;
  localparam logic [CHAR_BITS-1:0]  OFS_LC       = 7'd61;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } rdc_div_stat_t;

  // Digit value to ASCII; out-of-range values map to the last symbol
  function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [RADIX_BITS-1:0] d);
    logic [RADIX_BITS-1:0] dc;
    dc = (d > DIG_LAST_LC) ? DIG_LAST_LC : d;
    if (dc <= DIG_LAST_NUM) begin
      return OFS_NUM + {1'b0, dc};
    end else if (dc <= DIG_LAST_UC) begin
      return OFS_UC + {1'b0, dc};
    end else begin
      return OFS_LC + {1'b0, dc};
    end
  endfunction

endpackage

// ===== rtl/rdc_if.sv =====
interface rdc_in_if;
  logic                             valid;
  logic                             ready;
  logic [rdc_pkg::VALUE_BITS-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rdc_out_if;
  logic                             valid;
  logic                             ready;
  logic [rdc_pkg::CHAR_BITS-1:0]    digit_char;
  logic                             last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ===== rtl/rdc_divider.sv =====
module rdc_divider #(
  parameter int unsigned W = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [W-1:0]                      dividend_i,
  input  logic [rdc_pkg::RADIX_BITS-1:0]    divisor_i,
  output rdc_pkg::rdc_div_stat_t            stat_o,
  output logic [W-1:0]                      quotient_o,
  output logic [rdc_pkg::RADIX_BITS-1:0]    remainder_o
);
  import rdc_pkg::*;

  localparam int unsigned CW = $clog2(W);

  logic                  busy_q, done_q;
  logic [CW-1:0]         cnt_q;
  logic [W-1:0]          acc_q;
  logic [RADIX_BITS-1:0] rem_q, dvs_q;

  logic [RADIX_BITS:0]   trial, diff;
  logic                  ge;
  logic [RADIX_BITS-1:0] rem_d;

  // One restoring step per cycle; quotient bits shift in at the bottom
  assign trial = {rem_q, acc_q[W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};
  assign rem_d = ge ? diff[RADIX_BITS-1:0] : trial[RADIX_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = acc_q;
  assign remainder_o  = rem_q;

endmodule

// ===== rtl/radix_digit_converter_core.sv =====
// Radix digit converter. Each request carries an unsigned value (low VALUE_WIDTH bits
// used) and is turned into ASCII digits in the current radix (2 to 62, alphabet 0-9,
// A-Z, a-z), sent most significant first, one response per digit, last_digit set on
// the final one. A zero value gives the single digit '0'. The radix register resets to
// 10; written values of 0 or 1 act as 2 and 63 acts as 62; write it only while idle.
// Digits are found by a bit-serial restoring divider, one digit per division,
// least significant first, into a MAX_DIGITS-deep digit store; values needing more
// digits keep only the MAX_DIGITS least significant ones. Emission then reads the
// store and loads the output register for each digit, the load waiting on a stalled
// sink. One request is handled at a time; the next is taken while the final digit
// still waits in the output register.
module radix_digit_converter_core #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned MAX_DIGITS  = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rdc_pkg::RADIX_BITS-1:0] cfg_wdata_i,
  rdc_in_if.sink                         req_i,
  rdc_out_if.source                      dig_o
);
  import rdc_pkg::*;

  localparam int unsigned IW = $clog2(MAX_DIGITS);
  localparam int unsigned NW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_LOAD
  } state_e;

  state_e                state_q;
  logic [RADIX_BITS-1:0] radix_q;
  logic [RADIX_BITS-1:0] base;
  logic [NW-1:0]         cnt_q, cnt_inc;
  logic [IW-1:0]         rd_idx_q;
  logic [RADIX_BITS-1:0] rd_data_q;
  logic                  out_valid_q, out_last_q;
  logic [CHAR_BITS-1:0]  out_char_q;

  // Digit store, least significant digit at entry 0
  logic [RADIX_BITS-1:0] store_q [MAX_DIGITS];

  // Divider hookup
  rdc_div_stat_t         div_stat;
  logic                  div_start;
  logic [VALUE_WIDTH-1:0] div_dividend, div_quot;
  logic [RADIX_BITS-1:0] div_rem;
  logic                  more_digits;
  logic                  req_fire, out_free;

  // Clamp the radix register on use
  always_comb begin
    if (radix_q < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix_q;
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || dig_o.ready;

  // Digit count after the one just produced; at most MAX_DIGITS
  assign cnt_inc     = cnt_q + 1'b1;
  // Keep dividing while the quotient is nonzero and the store has room.
  // At least one division always runs, so zero gives the digit '0'.
  assign more_digits = (div_quot != '0) && (cnt_inc < NW'(MAX_DIGITS));

  assign div_start    = req_fire || (state_q == ST_DIV && div_stat.done && more_digits);
  assign div_dividend = req_fire ? req_i.value[VALUE_WIDTH-1:0] : div_quot;

  rdc_divider #(
    .W (VALUE_WIDTH)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (base),
    .stat_o      (div_stat),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // Radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  // Digit store: written as each remainder lands, read one entry per digit
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV && div_stat.done) begin
      store_q[cnt_q[IW-1:0]] <= div_rem;
    end
    if (state_q == ST_READ) begin
      rd_data_q <= store_q[rd_idx_q];
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_char_q  <= '0;
    end else begin
      if (out_valid_q && dig_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            cnt_q <= cnt_inc;
            if (!more_digits) begin
              // Emit from the most significant digit down
              rd_idx_q <= cnt_q[IW-1:0];
              state_q  <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= digit_to_char(rd_data_q);
            out_last_q  <= (rd_idx_q == '0);
            if (rd_idx_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              rd_idx_q <= rd_idx_q - 1'b1;
              state_q  <= ST_READ;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign dig_o.valid      = out_valid_q;
  assign dig_o.digit_char = out_char_q;
  assign dig_o.last_digit = out_last_q;

endmodule

// ===== tb/tb_radix_digit_converter_core.sv =====
`timescale 1ns / 1ps

module tb_radix_digit_converter_core;
  import rdc_pkg::*;

  // Idle odds per side, in percent.
  localparam int unsigned IDLE_PCT       = 16;
  // Quiet-cycle limit, set well above the slowest request: 64 radix-2 digits,
  // with no handshake while they are divided.
  localparam int unsigned STALL_LIMIT    = 20000;
  localparam int unsigned NUM_PHASES     = 12;
  localparam int unsigned RAND_PER_PHASE = 30;
  // Phase that runs with neither side idling.
  localparam int unsigned STEADY_PHASE   = 6;
  localparam int unsigned DRAIN_CYCLES   = 200;

  typedef struct {
    logic [CHAR_BITS-1:0] ch;
    logic                 last_flag;
  } digit_t;

  // Tracks the radix register, spells each accepted value into the digits the
  // block owes, and matches them against what comes out.
  class digit_ledger;
    digit_t                owed_digits[$];
    logic [RADIX_BITS-1:0] radix_reg;
    int unsigned           mismatches;
    int unsigned           values_seen;
    int unsigned           digits_seen;

    function new();
      radix_reg   = RADIX_RESET;
      mismatches  = 0;
      values_seen = 0;
      digits_seen = 0;
    endfunction

    function void set_radix(logic [RADIX_BITS-1:0] r);
      radix_reg = r;
    endfunction

    function int unsigned outstanding();
      return owed_digits.size();
    endfunction

    // Repeated division, least significant digit first, then queued MSB first.
    function void note_value(logic [VALUE_BITS-1:0] v);
      string                 alphabet;
      logic [VALUE_BITS-1:0] quot;
      logic [VALUE_BITS-1:0] base;
      logic [RADIX_BITS-1:0] store [64];
      logic [7:0]            code;
      int                    n;
      digit_t                d;
      alphabet = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
      base = radix_reg;
      if (base < RADIX_MIN) base = RADIX_MIN;
      if (base > RADIX_MAX) base = RADIX_MAX;
      quot = v;
      n = 0;
      if (quot == '0) begin
        store[0] = '0;
        n = 1;
      end else begin
        while (quot != '0 && n < 64) begin
          store[n] = RADIX_BITS'(quot % base);
          quot = quot / base;
          n++;
        end
      end
      for (int k = n - 1; k >= 0; k--) begin
        code        = alphabet[store[k]];
        d.ch        = code[CHAR_BITS-1:0];
        d.last_flag = (k == 0);
        owed_digits.push_back(d);
      end
      values_seen++;
    endfunction

    function void check_digit(logic [CHAR_BITS-1:0] ch, logic last_flag);
      digit_t want;
      digits_seen++;
      if (owed_digits.size() == 0) begin
        $display("%0t: unexpected digit, expected none, actual char %0d last %0b",
                 $time, ch, last_flag);
        mismatches++;
        return;
      end
      want = owed_digits.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: digit_char mismatch, expected %0d actual %0d",
                 $time, want.ch, ch);
        mismatches++;
      end
      if (last_flag !== want.last_flag) begin
        $display("%0t: last_digit mismatch, expected %0b actual %0b",
                 $time, want.last_flag, last_flag);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [RADIX_BITS-1:0] cfg_wdata_i;
  logic                  sink_ready = 1'b0;
  bit                    steady = 1'b0;
  int unsigned           quiet_cycles = 0;
  int unsigned           radix_writes = 0;
  digit_ledger           ledger = new();

  rdc_in_if  req_if ();
  rdc_out_if dig_if ();

  assign dig_if.ready = sink_ready;

  radix_digit_converter_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .dig_o       (dig_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Digit sink: random backpressure, none during the steady phase.
  always @(posedge clk_i) begin
    sink_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Every digit that moves is checked against the oldest owed digit.
  always @(posedge clk_i) begin
    if (rst_ni && dig_if.valid && dig_if.ready) begin
      ledger.check_digit(dig_if.digit_char, dig_if.last_digit);
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (dig_if.valid && dig_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d digits still owed",
               $time, STALL_LIMIT, ledger.outstanding());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Radix writes happen only with the block idle: drop valid and wait for every
  // owed digit, then make the write.
  task automatic write_radix(input logic [RADIX_BITS-1:0] r);
    req_if.valid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ledger.set_radix(r);
    radix_writes++;
  endtask

  // One request. Valid stays high across back-to-back requests; a gap lowers
  // it for at least one whole cycle before it rises again.
  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_if.valid <= 1'b1;
    req_if.value <= v;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    ledger.note_value(v);
  endtask

  // Random value of random bit length, so digit counts spread from 1 to 64
  // and the run stays short; zero now and then.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] v;
    int unsigned           nbits;
    if ($urandom_range(0, 15) == 0) return '0;
    nbits = $urandom_range(1, VALUE_BITS);
    v = {$urandom, $urandom};
    if (nbits < VALUE_BITS) v &= (64'd1 << nbits) - 64'd1;
    return v;
  endfunction

  initial begin
    logic [RADIX_BITS-1:0] radix_plan [NUM_PHASES];
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    req_if.valid <= 1'b0;
    req_if.value <= '0;

    // Reset value first, then the extremes, the clamped codes (0, 1 act as
    // 2; 63 acts as 62), a few ordinary bases and some random ones.
    radix_plan = '{RADIX_RESET, RADIX_MIN, RADIX_MAX, 6'd0, 6'd1, 6'd63,
                   6'd16, 6'd36, 6'd7, 6'd0, 6'd0, 6'd0};
    for (int i = 9; i < NUM_PHASES; i++) radix_plan[i] = RADIX_BITS'($urandom_range(0, 63));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase != 0) write_radix(radix_plan[phase]);
      steady = (phase == STEADY_PHASE);

      // Directed requests: zero, single digits, the digit-class boundaries
      // of the alphabet, all-ones, the top bit alone and alternating bits.
      case (phase)
        0: begin
          send_value(64'd0);
          send_value(64'd1);
          send_value(64'd9);
          send_value(64'd10);
          send_value(64'hFFFF_FFFF_FFFF_FFFF);
          send_value(64'h8000_0000_0000_0000);
          send_value(64'h5555_5555_5555_5555);
          send_value(64'hAAAA_AAAA_AAAA_AAAA);
        end
        1: begin
          // 64 binary digits, the deepest the digit store goes
          send_value(64'hFFFF_FFFF_FFFF_FFFF);
          send_value(64'd1);
          send_value(64'd0);
        end
        2: begin
          send_value(64'd9);
          send_value(64'd10);
          send_value(64'd35);
          send_value(64'd36);
          send_value(64'd61);
          send_value(64'd62);
          send_value(64'hFFFF_FFFF_FFFF_FFFF);
          send_value(64'd0);
        end
        3: send_value(64'd2);
        5: begin
          send_value(64'd61);
          send_value(64'd3843);
        end
        default: ;
      endcase

      for (int n = 0; n < RAND_PER_PHASE; n++) send_value(pick_value());
    end

    req_if.valid <= 1'b0;
    steady = 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d values into %0d digits across %0d radix writes",
             ledger.values_seen, ledger.digits_seen, radix_writes);
    $display("Bases covered: reset, 2, 62, clamped codes 0/1/63, plus mixed and random");
    if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
